// ===== src/las_pkg.sv =====
// Shared types and constants for the local alignment scorer.
// Used by las_cell, local_alignment_scorer_unit and the testbench; depends on nothing else.
`default_nettype none

package las_pkg;

    // parameter defaults
    localparam int MAX_QUERY_DEF  = 256;
    localparam int SCORE_BITS_DEF = 15;

    // fixed field widths
    localparam int SYM_BITS      = 8;
    localparam int COL_BITS      = 16;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 7;

    // item kinds
    localparam logic KIND_QUERY = 1'b0;
    localparam logic KIND_REF   = 1'b1;

    // register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_MATCH    = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MISMATCH = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_GAP      = 2'd2;

    // register reset values
    localparam logic [5:0] MATCH_RESET    = 6'd2;
    localparam logic [6:0] MISMATCH_RESET = 7'h7F;
    localparam logic [6:0] GAP_RESET      = 7'h7F;

    typedef struct packed {
        logic [5:0]        match_score;
        logic signed [6:0] mismatch_score;
        logic signed [6:0] gap_score;
    } cfg_t;

    // control part of a token moving down the cell chain
    typedef struct packed {
        logic valid;
        logic kind;
        logic last;     // final reference symbol
        logic written;  // query symbol already stored by an upstream cell
    } tok_ctrl_t;

endpackage

`default_nettype wire

// ===== src/las_cell.sv =====
// One query row of the systolic scoring chain: holds the row's symbol,
// column score and best cell, and registers the token for the next row.
// Depends on las_pkg.
`default_nettype none

module las_cell #(
    parameter int ROW        = 0,
    parameter int SCORE_BITS = las_pkg::SCORE_BITS_DEF,
    parameter int ROW_BITS   = 9
) (
    input  wire                            clk,
    input  wire                            rst_n,
    input  wire                            enable,
    input  wire las_pkg::cfg_t             cfg,
    input  wire las_pkg::tok_ctrl_t        ctrl_in,
    input  wire [las_pkg::SYM_BITS-1:0]    sym_in,
    input  wire [las_pkg::COL_BITS-1:0]    col_in,
    input  wire [SCORE_BITS-1:0]           up_in,
    input  wire [SCORE_BITS-1:0]           acc_val_in,
    input  wire [ROW_BITS-1:0]             acc_row_in,
    input  wire [las_pkg::COL_BITS-1:0]    acc_col_in,
    output las_pkg::tok_ctrl_t             ctrl_out,
    output logic [las_pkg::SYM_BITS-1:0]   sym_out,
    output logic [las_pkg::COL_BITS-1:0]   col_out,
    output logic [SCORE_BITS-1:0]          up_out,
    output logic [SCORE_BITS-1:0]          acc_val_out,
    output logic [ROW_BITS-1:0]            acc_row_out,
    output logic [las_pkg::COL_BITS-1:0]   acc_col_out
);

    localparam int W = SCORE_BITS + 2;
    localparam logic [ROW_BITS-1:0]   MY_ROW = ROW_BITS'(ROW + 1);
    localparam logic signed [W-1:0]   SMAX   = {2'b00, {SCORE_BITS{1'b1}}};

    // row state
    logic                          valid_reg;
    logic [las_pkg::SYM_BITS-1:0]  qsym_reg;
    logic [SCORE_BITS-1:0]         score_reg;    // this row, previous column
    logic [SCORE_BITS-1:0]         diag_reg;     // row above, previous column
    logic [SCORE_BITS-1:0]         best_val_reg;
    logic [las_pkg::COL_BITS-1:0]  best_col_reg;

    // token stage
    las_pkg::tok_ctrl_t            ctrl_reg;
    las_pkg::tok_ctrl_t            ctrl_next;
    logic [las_pkg::SYM_BITS-1:0]  sym_reg;
    logic [las_pkg::COL_BITS-1:0]  col_reg;
    logic [SCORE_BITS-1:0]         up_reg;
    logic [SCORE_BITS-1:0]         acc_val_reg;
    logic [ROW_BITS-1:0]           acc_row_reg;
    logic [las_pkg::COL_BITS-1:0]  acc_col_reg;

    logic                          ref_hit;
    logic                          qry_take;
    logic signed [W-1:0]           sub_ext;
    logic signed [W-1:0]           gap_ext;
    logic signed [W-1:0]           diag_sum;
    logic signed [W-1:0]           left_sum;
    logic signed [W-1:0]           up_sum;
    logic signed [W-1:0]           cell_max;
    logic [SCORE_BITS-1:0]         cell_sat;
    logic                          best_upd;
    logic [SCORE_BITS-1:0]         cand_val;
    logic [las_pkg::COL_BITS-1:0]  cand_col;
    logic                          acc_take;

    assign ref_hit  = ctrl_in.valid && (ctrl_in.kind == las_pkg::KIND_REF);
    assign qry_take = ctrl_in.valid && (ctrl_in.kind == las_pkg::KIND_QUERY)
                      && !valid_reg && !ctrl_in.written;

    always_comb
    begin
        ctrl_next         = ctrl_in;
        ctrl_next.written = ctrl_in.written | qry_take;
    end

    always_comb
    begin
        sub_ext  = (qsym_reg == sym_in)
                   ? {{(W-6){1'b0}}, cfg.match_score}
                   : {{(W-7){cfg.mismatch_score[6]}}, cfg.mismatch_score};
        gap_ext  = {{(W-7){cfg.gap_score[6]}}, cfg.gap_score};
        diag_sum = $signed({2'b00, diag_reg}) + sub_ext;
        left_sum = $signed({2'b00, score_reg}) + gap_ext;
        up_sum   = $signed({2'b00, up_in}) + gap_ext;
        cell_max = diag_sum;
        if (left_sum > cell_max)
        begin
            cell_max = left_sum;
        end
        if (up_sum > cell_max)
        begin
            cell_max = up_sum;
        end
        if (cell_max[W-1])
        begin
            cell_sat = '0;
        end
        else if (cell_max > SMAX)
        begin
            cell_sat = {SCORE_BITS{1'b1}};
        end
        else
        begin
            cell_sat = cell_max[SCORE_BITS-1:0];
        end
    end

    // first highest cell of this row; strict compare keeps the earliest column
    assign best_upd = ref_hit && valid_reg && (cell_sat > best_val_reg);
    assign cand_val = best_upd ? cell_sat : best_val_reg;
    assign cand_col = best_upd ? col_in : best_col_reg;
    // rows above already folded in; ties stay with them
    assign acc_take = cand_val > acc_val_in;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= 1'b0;
            score_reg    <= '0;
            diag_reg     <= '0;
            best_val_reg <= '0;
            best_col_reg <= '0;
            ctrl_reg     <= '0;
        end
        else if (enable)
        begin
            ctrl_reg <= ctrl_next;
            if (ref_hit && ctrl_in.last)
            begin
                // alignment ends here once the final column has passed
                valid_reg    <= 1'b0;
                score_reg    <= '0;
                diag_reg     <= '0;
                best_val_reg <= '0;
                best_col_reg <= '0;
            end
            else if (ref_hit)
            begin
                diag_reg <= up_in;
                if (valid_reg)
                begin
                    score_reg <= cell_sat;
                end
                if (best_upd)
                begin
                    best_val_reg <= cell_sat;
                    best_col_reg <= col_in;
                end
            end
            else if (qry_take)
            begin
                valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (enable)
        begin
            if (qry_take)
            begin
                qsym_reg <= sym_in;
            end
            sym_reg     <= sym_in;
            col_reg     <= col_in;
            up_reg      <= valid_reg ? cell_sat : '0;
            acc_val_reg <= acc_take ? cand_val : acc_val_in;
            acc_row_reg <= acc_take ? MY_ROW : acc_row_in;
            acc_col_reg <= acc_take ? cand_col : acc_col_in;
        end
    end

    assign ctrl_out    = ctrl_reg;
    assign sym_out     = sym_reg;
    assign col_out     = col_reg;
    assign up_out      = up_reg;
    assign acc_val_out = acc_val_reg;
    assign acc_row_out = acc_row_reg;
    assign acc_col_out = acc_col_reg;

endmodule

`default_nettype wire

// ===== src/local_alignment_scorer_unit.sv =====
// Top level of the local alignment scorer: stream ports, score registers,
// the chain of las_cell rows and the result register. Depends on las_pkg, las_cell.
`default_nettype none

// Channel   Dir   Transaction                   Payload
// s_*       in    one query or reference item   tdata symbol, tuser kind, tlast last
// m_*       out   one alignment result          tdata score, query pos, ref pos, truncated
// cfg_*     in    one register write            cfg_index, cfg_data
//
// An input transaction is taken every cycle while the result side is not stalled and
// no register write is taken in that cycle.
// Each item walks the row chain one cell per cycle while the chain is not frozen; the
// result of a final reference symbol is registered on m_* once it leaves the last cell.
// Query symbols are stored by the first empty cell they pass; one reaching the end
// unstored marks the query as truncated.
// cfg_ready is high only while no item is in the chain, which takes longer to empty while
// frozen; a register write holds s_tready low that cycle.
// A result held on m_* with m_tready low freezes the whole chain and s_tready.
// Reset (rst_n, asynchronous) empties the chain and restores the score registers.

module local_alignment_scorer_unit #(
    parameter int MAX_QUERY  = las_pkg::MAX_QUERY_DEF,
    parameter int SCORE_BITS = las_pkg::SCORE_BITS_DEF
) (
    input  wire                                  clk,
    input  wire                                  rst_n,
    // input stream
    input  wire                                  s_tvalid,
    output logic                                 s_tready,
    input  wire  [las_pkg::SYM_BITS-1:0]         s_tdata,   // [7:0] symbol
    input  wire                                  s_tuser,   // [0] kind
    input  wire                                  s_tlast,
    // result stream
    output logic                                 m_tvalid,
    input  wire                                  m_tready,
    // from bit 0: best_score, best_query_pos, best_ref_pos, query_truncated, zero pad
    output logic [((SCORE_BITS + $clog2(MAX_QUERY + 1) + las_pkg::COL_BITS + 1 + 7) / 8) * 8 - 1:0]
                                                 m_tdata,
    // register writes
    input  wire                                  cfg_valid,
    output logic                                 cfg_ready,
    input  wire  [las_pkg::CFG_IDX_BITS-1:0]     cfg_index,
    input  wire  [las_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

    localparam int ROW_BITS = $clog2(MAX_QUERY + 1);
    localparam int COL_BITS = las_pkg::COL_BITS;
    localparam int RES_BITS = SCORE_BITS + ROW_BITS + COL_BITS + 1;
    localparam int OUT_BITS = ((RES_BITS + 7) / 8) * 8;
    localparam int POS_LO   = SCORE_BITS;
    localparam int COL_LO   = SCORE_BITS + ROW_BITS;
    localparam int TRN_BIT  = SCORE_BITS + ROW_BITS + COL_BITS;
    localparam int IF_BITS  = $clog2(MAX_QUERY + 1);

    las_pkg::cfg_t            cfg_reg;
    logic [COL_BITS-1:0]      col_reg;
    logic [COL_BITS-1:0]      col_inc;
    logic [IF_BITS-1:0]       inflight_reg;
    logic [IF_BITS-1:0]       inflight_next;
    logic                     trunc_reg;
    logic                     out_valid_reg;
    logic [OUT_BITS-1:0]      out_data_reg;
    logic [OUT_BITS-1:0]      out_data_next;

    logic                     adv;
    logic                     in_acc;
    logic                     cfg_acc;
    logic                     end_valid;
    logic                     end_result;
    logic                     end_dropped;

    // chain links: element k feeds cell k
    las_pkg::tok_ctrl_t              chain_ctrl    [0:MAX_QUERY];
    logic [SCORE_BITS-1:0]           chain_acc_val [0:MAX_QUERY];
    logic [ROW_BITS-1:0]             chain_acc_row [0:MAX_QUERY];
    logic [COL_BITS-1:0]             chain_acc_col [0:MAX_QUERY];
    logic [las_pkg::SYM_BITS-1:0]    chain_sym     [0:MAX_QUERY-1];
    logic [COL_BITS-1:0]             chain_col     [0:MAX_QUERY-1];
    logic [SCORE_BITS-1:0]           chain_up      [0:MAX_QUERY-1];

    // whole chain moves together; held result blocks it; a register write keeps
    // items out for its cycle so no item ever sees two score settings
    assign adv       = !(out_valid_reg && !m_tready);
    assign cfg_ready = (inflight_reg == '0);
    assign cfg_acc   = cfg_valid && cfg_ready;
    assign s_tready  = adv && !cfg_acc;
    assign in_acc    = s_tvalid && s_tready;

    assign col_inc = (col_reg == {COL_BITS{1'b1}}) ? col_reg : col_reg + 1'b1;

    always_comb
    begin
        chain_ctrl[0].valid   = in_acc;
        chain_ctrl[0].kind    = s_tuser;
        chain_ctrl[0].last    = s_tlast && (s_tuser == las_pkg::KIND_REF);
        chain_ctrl[0].written = 1'b0;
    end
    assign chain_sym[0]     = s_tdata;
    assign chain_col[0]     = col_inc;
    assign chain_up[0]      = '0;
    assign chain_acc_val[0] = '0;
    assign chain_acc_row[0] = '0;
    assign chain_acc_col[0] = '0;

    for (genvar k = 0; k < MAX_QUERY; k++)
    begin : g_row
        if (k < MAX_QUERY - 1)
        begin : g_mid
            las_cell #(
                .ROW        (k),
                .SCORE_BITS (SCORE_BITS),
                .ROW_BITS   (ROW_BITS)
            ) u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .enable      (adv),
                .cfg         (cfg_reg),
                .ctrl_in     (chain_ctrl[k]),
                .sym_in      (chain_sym[k]),
                .col_in      (chain_col[k]),
                .up_in       (chain_up[k]),
                .acc_val_in  (chain_acc_val[k]),
                .acc_row_in  (chain_acc_row[k]),
                .acc_col_in  (chain_acc_col[k]),
                .ctrl_out    (chain_ctrl[k+1]),
                .sym_out     (chain_sym[k+1]),
                .col_out     (chain_col[k+1]),
                .up_out      (chain_up[k+1]),
                .acc_val_out (chain_acc_val[k+1]),
                .acc_row_out (chain_acc_row[k+1]),
                .acc_col_out (chain_acc_col[k+1])
            );
        end
        else
        begin : g_tail
            // last row: only the token control and running best leave the chain
            las_cell #(
                .ROW        (k),
                .SCORE_BITS (SCORE_BITS),
                .ROW_BITS   (ROW_BITS)
            ) u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .enable      (adv),
                .cfg         (cfg_reg),
                .ctrl_in     (chain_ctrl[k]),
                .sym_in      (chain_sym[k]),
                .col_in      (chain_col[k]),
                .up_in       (chain_up[k]),
                .acc_val_in  (chain_acc_val[k]),
                .acc_row_in  (chain_acc_row[k]),
                .acc_col_in  (chain_acc_col[k]),
                .ctrl_out    (chain_ctrl[k+1]),
                .sym_out     (),
                .col_out     (),
                .up_out      (),
                .acc_val_out (chain_acc_val[k+1]),
                .acc_row_out (chain_acc_row[k+1]),
                .acc_col_out (chain_acc_col[k+1])
            );
        end
    end

    // chain exit
    assign end_valid   = adv && chain_ctrl[MAX_QUERY].valid;
    assign end_result  = end_valid && (chain_ctrl[MAX_QUERY].kind == las_pkg::KIND_REF)
                         && chain_ctrl[MAX_QUERY].last;
    assign end_dropped = end_valid && (chain_ctrl[MAX_QUERY].kind == las_pkg::KIND_QUERY)
                         && !chain_ctrl[MAX_QUERY].written;

    always_comb
    begin
        inflight_next = inflight_reg;
        if (in_acc && !end_valid)
        begin
            inflight_next = inflight_reg + 1'b1;
        end
        else if (!in_acc && end_valid)
        begin
            inflight_next = inflight_reg - 1'b1;
        end
    end

    always_comb
    begin
        out_data_next                         = '0;
        out_data_next[SCORE_BITS-1:0]         = chain_acc_val[MAX_QUERY];
        out_data_next[COL_LO-1:POS_LO]        = chain_acc_row[MAX_QUERY];
        out_data_next[TRN_BIT-1:COL_LO]       = chain_acc_col[MAX_QUERY];
        out_data_next[TRN_BIT]                = trunc_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.match_score    <= las_pkg::MATCH_RESET;
            cfg_reg.mismatch_score <= las_pkg::MISMATCH_RESET;
            cfg_reg.gap_score      <= las_pkg::GAP_RESET;
            col_reg                <= '0;
            inflight_reg           <= '0;
            trunc_reg              <= 1'b0;
            out_valid_reg          <= 1'b0;
        end
        else
        begin
            if (cfg_acc)
            begin
                unique case (cfg_index)
                    las_pkg::CFG_MATCH:    cfg_reg.match_score    <= cfg_data[5:0];
                    las_pkg::CFG_MISMATCH: cfg_reg.mismatch_score <= cfg_data;
                    las_pkg::CFG_GAP:      cfg_reg.gap_score      <= cfg_data;
                    default:               ;
                endcase
            end

            // reference position counts at entry; cleared by the final symbol
            if (in_acc && (s_tuser == las_pkg::KIND_REF))
            begin
                col_reg <= s_tlast ? '0 : col_inc;
            end

            inflight_reg <= inflight_next;

            if (end_result)
            begin
                trunc_reg     <= 1'b0;
                out_valid_reg <= 1'b1;
            end
            else
            begin
                if (end_dropped)
                begin
                    trunc_reg <= 1'b1;
                end
                if (m_tready)
                begin
                    out_valid_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (end_result)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // config only taken with an empty chain
    a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready |-> !chain_ctrl[MAX_QUERY].valid)
        else $error("register write window open with a token at the chain exit");

    a_inflight_bound: assert property (@(posedge clk) disable iff (!rst_n)
        inflight_reg <= IF_BITS'(MAX_QUERY))
        else $error("more tokens counted than chain stages");

    a_col_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && s_tlast && (s_tuser == las_pkg::KIND_REF)) |=> (col_reg == '0))
        else $error("reference position not cleared after final symbol");

    a_zero_result: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((m_tdata[SCORE_BITS-1:0] == '0) == (m_tdata[COL_LO-1:POS_LO] == '0)))
        else $error("query position and score disagree on an empty alignment");

endmodule

`default_nettype wire

// ===== tb/tb_local_alignment_scorer_unit.sv =====
// Self-checking testbench for local_alignment_scorer_unit. Query and reference items are
// driven on the input stream, each alignment result is predicted here and checked field
// by field. Depends on las_pkg and local_alignment_scorer_unit.

module tb_local_alignment_scorer_unit;

    localparam int MAX_Q          = las_pkg::MAX_QUERY_DEF;
    localparam int SCORE_W        = las_pkg::SCORE_BITS_DEF;
    localparam int QPOS_W         = $clog2(MAX_Q + 1);
    localparam int REF_W          = las_pkg::COL_BITS;
    localparam int SYM_W          = las_pkg::SYM_BITS;
    localparam int OUT_W          = ((SCORE_W + QPOS_W + REF_W + 1 + 7) / 8) * 8;
    localparam int SCORE_TOP      = (1 << SCORE_W) - 1;
    localparam int REF_TOP        = (1 << REF_W) - 1;
    // the chain is MAX_QUERY cells deep; this wait after the last result lets it run dry
    localparam int SETTLE_CYCLES  = MAX_Q + 16;
    // cycles with no transaction on any channel before the run is abandoned
    localparam int WATCHDOG_LIMIT = 20 * MAX_Q;
    localparam int GAP_PCT        = 13;
    localparam int RANDOM_ITEMS   = 1280;

    // one alignment result, at the widths of the result port
    typedef struct packed {
        logic [SCORE_W-1:0]  score;
        logic [QPOS_W-1:0]   query_pos;
        logic [REF_W-1:0]    ref_pos;
        logic                truncated;
    } alignment_t;

    logic                     clk       = 1'b0;
    logic                     rst_n     = 1'b0;
    logic                     s_tvalid  = 1'b0;
    logic                     s_tready;
    logic [SYM_W-1:0]         s_tdata   = '0;   // [7:0] symbol
    logic                     s_tuser   = 1'b0; // [0] kind
    logic                     s_tlast   = 1'b0;
    logic                     m_tvalid;
    logic                     m_tready  = 1'b0;
    // from bit 0: best_score, best_query_pos, best_ref_pos, query_truncated, zero pad
    logic [OUT_W-1:0]         m_tdata;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [las_pkg::CFG_IDX_BITS-1:0]  cfg_index = '0;
    logic [las_pkg::CFG_DATA_BITS-1:0] cfg_data  = '0;

    // scoreboard bookkeeping
    int  failures      = 0;
    int  items_sent    = 0;
    int  results_seen  = 0;
    int  writes_done   = 0;
    int  idle_cycles   = 0;
    bit  no_gaps       = 1'b0;

    // alignment model: score registers, query rows, previous column and running best
    int                  match_pts;
    int                  mismatch_pts;
    int                  gap_pts;
    logic [SYM_W-1:0]    query_syms [MAX_Q];
    logic [SCORE_W-1:0]  prev_column [MAX_Q];
    int                  query_len;
    int                  ref_len;
    alignment_t          running_best;
    alignment_t          expected_alignments [$];

    // symbol source for random sequences: a narrow alphabet makes matches likely
    logic [SYM_W-1:0]    alphabet [4];
    bit                  wide_alphabet;

    alignment_t          seen_result;
    alignment_t          due_result;

    always #5 clk = ~clk;

    local_alignment_scorer_unit #(
        .MAX_QUERY  (MAX_Q),
        .SCORE_BITS (SCORE_W)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    function automatic bit take_gap();
        return !no_gaps && ($urandom_range(99) < GAP_PCT);
    endfunction

    function automatic logic [SYM_W-1:0] pick_symbol();
        if (wide_alphabet)
        begin
            return SYM_W'($urandom_range(255));
        end
        return alphabet[$urandom_range(3)];
    endfunction

    // end of an alignment (and reset): query rows, column and best cell all cleared
    function automatic void clear_alignment_state();
        foreach (prev_column[k])
            prev_column[k] = '0;
        query_len    = 0;
        ref_len      = 0;
        running_best = '0;
    endfunction

    function automatic void check_field(string what, int want, int got);
        if (want != got)
        begin
            $display("%0t: %s expected %0d actual %0d", $time, what, want, got);
            failures++;
        end
    endfunction

    // Advance the alignment model by one accepted item; a final reference symbol
    // queues the expected result and clears the alignment.
    task automatic score_alignment_item(input logic kind, input logic [SYM_W-1:0] sym,
                                        input logic last);
        int r, diag_src, up, left_src, d, w, n, v;
        if (kind == las_pkg::KIND_QUERY)
        begin
            // last is meaningless on a query item; a full store drops the symbol
            if (query_len < MAX_Q)
            begin
                query_syms[query_len] = sym;
                query_len++;
            end
            else
            begin
                running_best.truncated = 1'b1;
            end
        end
        else
        begin
            if (ref_len < REF_TOP)
                ref_len++;
            diag_src = 0;
            up       = 0;
            for (r = 0; r < query_len; r++)
            begin
                left_src = prev_column[r];
                d = diag_src + ((query_syms[r] == sym) ? match_pts : mismatch_pts);
                w = left_src + gap_pts;
                n = up + gap_pts;
                v = d;
                if (w > v)
                    v = w;
                if (n > v)
                    v = n;
                if (v < 0)
                    v = 0;
                // clamp; cannot trigger at 256 rows x 63 points, kept for other sizes
                if (v > SCORE_TOP)
                    v = SCORE_TOP;
                // ties go to the lower query row, never to a later column of the same row
                if (v > int'(running_best.score) ||
                    (v > 0 && v == int'(running_best.score) &&
                     r + 1 < int'(running_best.query_pos)))
                begin
                    running_best.score     = SCORE_W'(v);
                    running_best.query_pos = QPOS_W'(r + 1);
                    running_best.ref_pos   = REF_W'(ref_len);
                end
                prev_column[r] = SCORE_W'(v);
                diag_src       = left_src;
                up             = v;
            end
            if (last)
            begin
                expected_alignments.push_back(running_best);
                clear_alignment_state();
            end
        end
    endtask

    // One input transaction. Called and returns at a falling edge; tvalid is left high
    // so that back-to-back items never lower and raise it in the same time step.
    task automatic send_item(input logic kind, input logic [SYM_W-1:0] sym,
                             input logic last);
        while (take_gap())
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= sym;
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        score_alignment_item(kind, sym, last);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic write_register(input logic [las_pkg::CFG_IDX_BITS-1:0] idx,
                                  input logic [las_pkg::CFG_DATA_BITS-1:0] value);
        while (take_gap())
        begin
            cfg_valid <= 1'b0;
            @(negedge clk);
        end
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            las_pkg::CFG_MATCH:    match_pts    = value[5:0];
            las_pkg::CFG_MISMATCH: mismatch_pts = $signed(value);
            las_pkg::CFG_GAP:      gap_pts      = $signed(value);
            default:               ;
        endcase
        writes_done++;
        @(negedge clk);
    endtask

    // Stop sending, wait for every expected result, then let the chain run dry:
    // trailing query or non-final reference items leave no result to wait for.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (expected_alignments.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES)
            @(negedge clk);
    endtask

    // score registers only change with the block idle
    task automatic set_scores(input int m, input int mm, input int g);
        settle();
        write_register(las_pkg::CFG_MATCH, 7'(m));
        write_register(las_pkg::CFG_MISMATCH, 7'(mm));
        write_register(las_pkg::CFG_GAP, 7'(g));
        cfg_valid <= 1'b0;
    endtask

    // -------------------------------------------------------------------------
    // directed tests, run under the reset scores unless they set their own
    // -------------------------------------------------------------------------

    // no query rows: score and both positions zero, also after a longer reference
    task automatic test_empty_query();
        send_item(las_pkg::KIND_REF, 8'h00, 1'b1);
        send_item(las_pkg::KIND_REF, 8'hFF, 1'b0);
        send_item(las_pkg::KIND_REF, 8'h00, 1'b1);
    endtask

    // last set on query items must not end anything; symbol extremes on both kinds
    task automatic test_last_on_query();
        send_item(las_pkg::KIND_QUERY, 8'h00, 1'b1);
        send_item(las_pkg::KIND_QUERY, 8'hFF, 1'b1);
        send_item(las_pkg::KIND_REF, 8'hFF, 1'b0);
        send_item(las_pkg::KIND_REF, 8'h00, 1'b0);
        send_item(las_pkg::KIND_REF, 8'hFF, 1'b1);
    endtask

    // row 2 scores first, then row 1 equals it in a later column and must take over
    task automatic test_tie_break();
        send_item(las_pkg::KIND_QUERY, 8'h41, 1'b0);
        send_item(las_pkg::KIND_QUERY, 8'h42, 1'b0);
        send_item(las_pkg::KIND_REF, 8'h42, 1'b0);
        send_item(las_pkg::KIND_REF, 8'h41, 1'b0);
        send_item(las_pkg::KIND_REF, 8'h41, 1'b1);
    endtask

    // a query symbol between reference symbols becomes a new row with a zero column
    task automatic test_query_after_reference();
        send_item(las_pkg::KIND_QUERY, 8'h11, 1'b0);
        send_item(las_pkg::KIND_REF, 8'h22, 1'b0);
        send_item(las_pkg::KIND_QUERY, 8'h33, 1'b0);
        send_item(las_pkg::KIND_REF, 8'h33, 1'b0);
        send_item(las_pkg::KIND_REF, 8'h11, 1'b1);
    endtask

    // match at both extremes, penalties at zero and -63, then back to the reset values
    task automatic test_register_settings();
        int s;
        for (s = 0; s < 4; s++)
        begin
            case (s)
                0:       set_scores(0, 0, 0);
                1:       set_scores(63, -63, -63);
                2:       set_scores(63, 0, 0);
                default: set_scores(las_pkg::MATCH_RESET, $signed(las_pkg::MISMATCH_RESET),
                                    $signed(las_pkg::GAP_RESET));
            endcase
            send_item(las_pkg::KIND_QUERY, 8'h00, 1'b0);
            send_item(las_pkg::KIND_QUERY, 8'hFF, 1'b0);
            send_item(las_pkg::KIND_QUERY, 8'h55, 1'b0);
            send_item(las_pkg::KIND_REF, 8'hFF, 1'b0);
            send_item(las_pkg::KIND_REF, 8'h55, 1'b0);
            send_item(las_pkg::KIND_REF, 8'h00, 1'b1);
        end
    endtask

    // two symbols past capacity are dropped and flagged; the flag clears afterwards
    task automatic test_query_full();
        repeat (MAX_Q + 2)
            send_item(las_pkg::KIND_QUERY, SYM_W'($urandom_range(255)), 1'b0);
        send_item(las_pkg::KIND_REF, query_syms[3], 1'b0);
        send_item(las_pkg::KIND_REF, query_syms[4], 1'b0);
        send_item(las_pkg::KIND_REF, query_syms[5], 1'b0);
        send_item(las_pkg::KIND_REF, query_syms[MAX_Q-1], 1'b1);
        send_item(las_pkg::KIND_QUERY, 8'h10, 1'b0);
        send_item(las_pkg::KIND_REF, 8'h10, 1'b1);
    endtask

    // Mostly well-formed alignments with random content, some empty queries,
    // occasional full queries, late query rows, and bursts of raw noise.
    task automatic random_alignments(input int n_items);
        int stop_at, style, qlen, rlen, i;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at)
        begin
            style         = $urandom_range(19);
            wide_alphabet = ($urandom_range(3) == 0);
            foreach (alphabet[k])
                alphabet[k] = SYM_W'($urandom_range(255));
            if (style == 0)
            begin
                repeat ($urandom_range(1, 8))
                    send_item(1'($urandom_range(1)), SYM_W'($urandom_range(255)),
                              $urandom_range(3) == 0);
            end
            else
            begin
                if (style == 1)
                begin
                    qlen = 0;
                    rlen = $urandom_range(1, 3);
                end
                else
                begin
                    qlen = ($urandom_range(19) == 0) ? $urandom_range(200, MAX_Q + 4)
                                                     : $urandom_range(1, 12);
                    rlen = $urandom_range(1, 20);
                end
                repeat (qlen)
                    send_item(las_pkg::KIND_QUERY, pick_symbol(), $urandom_range(7) == 0);
                for (i = 0; i < rlen; i++)
                begin
                    if ($urandom_range(15) == 0)
                        send_item(las_pkg::KIND_QUERY, pick_symbol(), 1'b0);
                    send_item(las_pkg::KIND_REF, pick_symbol(), i == rlen - 1);
                end
            end
        end
    endtask

    // includes the long stretch of uninterrupted traffic on the input and result streams
    task automatic test_random_traffic();
        set_scores(63, -63, -63);
        random_alignments(RANDOM_ITEMS / 4);
        set_scores(63, 0, 0);
        random_alignments(RANDOM_ITEMS / 4);
        set_scores($urandom_range(63), -$urandom_range(63), -$urandom_range(63));
        random_alignments(RANDOM_ITEMS / 4);
        // small penalties give long gapped paths
        set_scores($urandom_range(1, 63), -$urandom_range(3), -$urandom_range(3));
        no_gaps = 1'b1;
        random_alignments(RANDOM_ITEMS / 8);
        no_gaps = 1'b0;
        random_alignments(RANDOM_ITEMS / 8);
    endtask

    // -------------------------------------------------------------------------
    // result side: random back-pressure, and each result transaction is
    // compared with the oldest expectation
    // -------------------------------------------------------------------------
    always @(negedge clk)
        m_tready <= !take_gap();

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            seen_result.score     = m_tdata[SCORE_W-1:0];
            seen_result.query_pos = m_tdata[SCORE_W +: QPOS_W];
            seen_result.ref_pos   = m_tdata[SCORE_W+QPOS_W +: REF_W];
            seen_result.truncated = m_tdata[SCORE_W+QPOS_W+REF_W];
            results_seen++;
            if (expected_alignments.size() == 0)
            begin
                $display("%0t: result with nothing expected: score %0d query_pos %0d ref_pos %0d",
                         $time, seen_result.score, seen_result.query_pos, seen_result.ref_pos);
                failures++;
            end
            else
            begin
                due_result = expected_alignments.pop_front();
                check_field("best_score", due_result.score, seen_result.score);
                check_field("best_query_pos", due_result.query_pos, seen_result.query_pos);
                check_field("best_ref_pos", due_result.ref_pos, seen_result.ref_pos);
                check_field("query_truncated", due_result.truncated, seen_result.truncated);
            end
        end
    end

    // watchdog: any transaction on any channel counts as progress
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            begin
                idle_cycles <= 0;
            end
            else if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no transaction for %0d cycles, %0d results outstanding",
                         $time, idle_cycles, expected_alignments.size());
                $display("tb_local_alignment_scorer_unit NOT OK");
                $finish;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial
    begin
        match_pts    = las_pkg::MATCH_RESET;
        mismatch_pts = $signed(las_pkg::MISMATCH_RESET);
        gap_pts      = $signed(las_pkg::GAP_RESET);
        clear_alignment_state();
        repeat (5)
            @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_empty_query();
        test_last_on_query();
        test_tie_break();
        test_query_after_reference();
        test_register_settings();
        test_query_full();
        test_random_traffic();
        settle();

        $display("Run: %0d item transactions, %0d results checked, %0d register writes.",
                 items_sent, results_seen, writes_done);
        $display("Covered empty and full queries, row ties, late rows, score register extremes.");
        if (failures == 0)
        begin
            $display("tb_local_alignment_scorer_unit OK");
        end
        else
        begin
            $display("tb_local_alignment_scorer_unit NOT OK");
        end
        $finish;
    end

endmodule
